@@ rtl/core/xds_pkg.sv @@
// ----------------------------------------------------------------------------
// xds_pkg
// shared types and codes of the xds packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package xds_pkg;

  localparam int CODE_W   = 7;
  localparam int CLS_W    = 3;
  localparam int CALC_W   = 10;

  localparam logic [CODE_W-1:0] HDR_LO    = 7'd1;
  localparam logic [CODE_W-1:0] HDR_HI    = 7'd14;
  localparam logic [CODE_W-1:0] TERM_CODE = 7'd15;
  localparam logic [CODE_W-1:0] CONT_LO   = 7'h20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_WR2,
    ST_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic exec;
    logic wr2;
    logic rd;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic emit_go;
    logic wr2_go;
    logic last;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/xds_pair_if.sv @@
// ----------------------------------------------------------------------------
// xds_pair_if
// channel of caption byte pairs with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface xds_pair_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] first_byte;
  logic [7:0] second_byte;

  modport source (output valid, command, first_byte, second_byte, input ready);
  modport sink (input valid, command, first_byte, second_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/xds_byte_if.sv @@
// ----------------------------------------------------------------------------
// xds_byte_if
// channel of delivered payload bytes with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface xds_byte_if;
  logic       valid;
  logic       ready;
  logic [1:0] packet_class;
  logic [4:0] packet_subclass;
  logic [6:0] payload_byte;
  logic [4:0] byte_index;
  logic       last_byte;

  modport source (output valid, packet_class, packet_subclass, payload_byte,
                  byte_index, last_byte, input ready);
  modport sink (input valid, packet_class, packet_subclass, payload_byte,
                byte_index, last_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/xds_ctrl.sv @@
// ----------------------------------------------------------------------------
// xds_ctrl
// sequencer: accept, slot lookup, update, second store, payload burst
// ----------------------------------------------------------------------------
`default_nettype none

module xds_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  xds_pkg::status_t st,
  output xds_pkg::cmd_t    cmd
);
  import xds_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: state_next = ST_EXEC;
      ST_EXEC: begin
        priority if (st.emit_go) state_next = ST_RD;
        else if (st.wr2_go) state_next = ST_WR2;
        else state_next = ST_IDLE;
      end
      ST_WR2: state_next = ST_IDLE;
      ST_RD: state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_next = st.last ? ST_IDLE : ST_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_LOOKUP: cmd.lookup = 1'b1;
      ST_EXEC:   cmd.exec = 1'b1;
      ST_WR2:    cmd.wr2 = 1'b1;
      ST_RD:     cmd.rd = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.step  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/xds_dpath.sv @@
// ----------------------------------------------------------------------------
// xds_dpath
// pair decode, slot state, payload store and burst read
// ----------------------------------------------------------------------------
`default_nettype none

module xds_dpath #(
  parameter int NUM_CLASSES    = 4,
  parameter int NUM_SUBCLASSES = 24,
  parameter int PAYLOAD_BYTES  = 32
) (
  input  wire              clk,
  input  wire              rst,
  input  xds_pkg::cmd_t    cmd,
  output xds_pkg::status_t st,
  input  wire              command,
  input  wire  [7:0]       first_byte,
  input  wire  [7:0]       second_byte,
  output logic [1:0]       packet_class,
  output logic [4:0]       packet_subclass,
  output logic [6:0]       payload_byte,
  output logic [4:0]       byte_index,
  output logic             last_byte
);
  import xds_pkg::*;

  localparam int NSLOTS = NUM_CLASSES * NUM_SUBCLASSES;
  localparam int SW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int LW     = $clog2(PAYLOAD_BYTES + 1);
  localparam int AW     = $clog2(NSLOTS * PAYLOAD_BYTES);
  localparam int MW     = LW + CODE_W;

  localparam logic [CALC_W-1:0] NS_C = CALC_W'(NUM_SUBCLASSES);
  localparam logic [AW-1:0]     PB_A = AW'(PAYLOAD_BYTES);
  localparam logic [LW:0]       PB_L = (LW+1)'(PAYLOAD_BYTES);

  logic              cmd_q;
  logic              par_q;
  logic [CODE_W-1:0] c1_q;
  logic [CODE_W-1:0] c2_q;

  logic              cur_vld;
  logic [CLS_W-1:0]  cur_cls;
  logic [CODE_W-1:0] cur_sub;
  logic [NSLOTS-1:0] slot_vld;

  logic [MW-1:0]     meta_mem [NSLOTS];
  logic [MW-1:0]     meta_q;
  logic [SW-1:0]     slot_r;

  logic [CODE_W-1:0] payload_mem [NSLOTS * PAYLOAD_BYTES];
  logic [CODE_W-1:0] pay_q;
  logic [LW-1:0]     e_idx;
  logic [LW-1:0]     e_len;

  logic              is_hdr, is_term, is_cont, hdr_ok, use_hdr;
  logic [CODE_W-1:0] c1_m1;
  logic [CLS_W-1:0]  hdr_cls;
  logic [CALC_W-1:0] slot_calc;
  logic [SW-1:0]     slot_sel;
  logic [LW-1:0]     meta_len;
  logic [CODE_W-1:0] meta_sum;
  logic [CODE_W-1:0] sum_upd;
  logic              sv, pair_ok, cont_ok, hdr_start, meta_we;
  logic [LW:0]       len_ext, new_len;
  logic [MW-1:0]     meta_wd;
  logic [AW-1:0]     base, wr_addr, rd_addr;
  logic              wr_en;
  logic [CODE_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      par_q <= (^first_byte) & (^second_byte);
      c1_q  <= first_byte[6:0];
      c2_q  <= second_byte[6:0];
    end
  end

  // pair decode
  always_comb begin
    is_hdr    = (c1_q >= HDR_LO) && (c1_q <= HDR_HI);
    is_term   = (c1_q == TERM_CODE);
    is_cont   = (c1_q >= CONT_LO);
    c1_m1     = c1_q - 7'd1;
    hdr_cls   = c1_m1[3:1];
    hdr_ok    = (hdr_cls < CLS_W'(NUM_CLASSES)) &&
                ({1'b0, c2_q} < 8'(NUM_SUBCLASSES));
    use_hdr   = !cmd_q && par_q && is_hdr && hdr_ok;
    slot_calc = use_hdr ? (CALC_W'(hdr_cls) * NS_C + CALC_W'(c2_q))
                        : (CALC_W'(cur_cls) * NS_C + CALC_W'(cur_sub));
    slot_sel  = slot_calc[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      slot_r <= slot_sel;
      meta_q <= meta_mem[slot_sel];
    end
  end

  // slot update
  always_comb begin
    meta_len  = meta_q[MW-1:CODE_W];
    meta_sum  = meta_q[CODE_W-1:0];
    sum_upd   = meta_sum + c1_q + c2_q;
    sv        = slot_vld[slot_r];
    pair_ok   = !cmd_q && par_q;
    len_ext   = (LW+1)'(meta_len);
    cont_ok   = pair_ok && is_cont && cur_vld && sv && (len_ext != PB_L);
    hdr_start = pair_ok && is_hdr && hdr_ok && c1_q[0];
    new_len   = len_ext + (LW+1)'(1) + (LW+1)'(c2_q != '0);
    if (new_len > PB_L) new_len = PB_L;
    meta_we   = cmd.exec && (hdr_start || cont_ok);
    meta_wd   = hdr_start ? {{LW{1'b0}}, CODE_W'(c1_q + c2_q)}
                          : {new_len[LW-1:0], sum_upd};
    st.emit_go = cmd.exec && pair_ok && is_term && cur_vld && sv &&
                 (sum_upd == '0) && (meta_len != '0);
    st.wr2_go  = cont_ok && ((len_ext + (LW+1)'(1)) < PB_L);
    st.last    = ((LW+1)'(e_idx) + (LW+1)'(1)) == (LW+1)'(e_len);
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[slot_r] <= meta_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      cur_vld  <= 1'b0;
      cur_cls  <= '0;
      cur_sub  <= '0;
    end else if (cmd.exec) begin
      priority if (cmd_q) begin
        slot_vld <= '0;
        cur_vld  <= 1'b0;
      end else if (!par_q || (is_hdr && !hdr_ok)) begin
        if (cur_vld) slot_vld[slot_r] <= 1'b0;
        cur_vld <= 1'b0;
      end else if (is_hdr) begin
        cur_cls <= hdr_cls;
        cur_sub <= c2_q;
        if (c1_q[0]) begin
          slot_vld[slot_r] <= 1'b1;
          cur_vld          <= 1'b1;
        end else begin
          cur_vld <= sv;
        end
      end else if (is_term) begin
        if (cur_vld) slot_vld[slot_r] <= 1'b0;
        cur_vld <= 1'b0;
      end else begin
        if (is_cont && cur_vld && !cont_ok) begin
          slot_vld[slot_r] <= 1'b0;
          cur_vld          <= 1'b0;
        end
      end
    end
  end

  // payload store
  always_comb begin
    base    = AW'(slot_r) * PB_A;
    wr_en   = (cmd.exec && cont_ok) || cmd.wr2;
    wr_addr = cmd.wr2 ? (base + AW'(meta_len) + AW'(1)) : (base + AW'(meta_len));
    wr_data = cmd.wr2 ? c2_q : c1_q;
    rd_addr = base + AW'(e_idx);
  end

  always_ff @(posedge clk) begin
    if (wr_en) payload_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) pay_q <= payload_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      e_idx <= '0;
      e_len <= meta_len;
    end else if (cmd.step) begin
      e_idx <= e_idx + LW'(1);
    end
  end

  assign packet_class    = cur_cls[1:0];
  assign packet_subclass = cur_sub[4:0];
  assign payload_byte    = pay_q;
  assign byte_index      = 5'(e_idx);
  assign last_byte       = st.last;

endmodule

`default_nettype wire

@@ rtl/core/xds_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// xds_packet_deframer
// xds packet deframer for closed-caption byte pairs
//
// pairs: one transfer carries a command bit and two raw caption bytes.
// payload: one transfer per delivered payload byte, tagged with class,
//   subclass, byte index and a last flag on the final byte.
// a pair is taken only while the block is idle. each pair passes accept,
//   slot lookup and update; a content pair that stores two bytes adds a
//   second store step. after a valid terminator each payload byte is a
//   store read, then output, and the pairs channel stays held until the
//   burst ends, including any receiver stall.
// each update waits for the slot table lookup before it, and the second
//   byte of a content pair waits for the single write port of the store.
// when the receiver stalls, the current byte holds on the payload channel
//   and no pair is taken until the burst ends.
// reset clears the slot valid flags and the current slot at once; no
//   clearing pass is needed and the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module xds_packet_deframer #(
  parameter int NUM_CLASSES    = 4,
  parameter int NUM_SUBCLASSES = 24,
  parameter int PAYLOAD_BYTES  = 32
) (
  input wire         clk,
  input wire         rst,
  xds_pair_if.sink   pairs,
  xds_byte_if.source payload
);
  import xds_pkg::*;

  cmd_t    cmd;
  status_t st;

  xds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pairs.valid),
    .in_ready  (pairs.ready),
    .out_valid (payload.valid),
    .out_ready (payload.ready),
    .st        (st),
    .cmd       (cmd)
  );

  xds_dpath #(
    .NUM_CLASSES    (NUM_CLASSES),
    .NUM_SUBCLASSES (NUM_SUBCLASSES),
    .PAYLOAD_BYTES  (PAYLOAD_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .command         (pairs.command),
    .first_byte      (pairs.first_byte),
    .second_byte     (pairs.second_byte),
    .packet_class    (payload.packet_class),
    .packet_subclass (payload.packet_subclass),
    .payload_byte    (payload.payload_byte),
    .byte_index      (payload.byte_index),
    .last_byte       (payload.last_byte)
  );

endmodule

`default_nettype wire
